>>> hw/rtl/kws_pkg.sv
// ----------------------------------------------------------------------------
// kws_pkg
// Shared sizes and types for the keyed window statistics block.
// ----------------------------------------------------------------------------
package kws_pkg;

  localparam int SENSORS   = 10;
  localparam int WINDOW    = 60;
  localparam int SAMPLE_W  = 32;
  localparam int KEY_W     = 64;
  localparam int COUNT_W   = 6;
  localparam int SLOT_W    = (SENSORS > 1) ? $clog2(SENSORS) : 1;
  localparam int KCNT_W    = $clog2(SENSORS + 1);
  localparam int POS_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W     = $clog2(WINDOW + 1);
  localparam int DEPTH     = SENSORS * WINDOW;
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SUM_W     = SAMPLE_W + CNT_W + 1;
  localparam int SQ_W      = 2 * SAMPLE_W + CNT_W;
  localparam int DIV_W     = SQ_W;
  localparam int VAR_W     = 2 * SAMPLE_W;
  localparam int ROOT_W    = VAR_W / 2;

  typedef enum logic [0:0] {
    OP_ADD   = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [0:0] {
    ST_OK   = 1'b0,
    ST_MISS = 1'b1
  } status_e;

  typedef struct packed {
    logic start;
    logic done;
  } unit_ctrl_t;

endpackage

>>> hw/rtl/keyed_window_statistics_core.sv
// ----------------------------------------------------------------------------
// keyed_window_statistics_core
// Per-key sliding windows of Q16.16 samples with min, max, mean and
// standard deviation queries.
// ----------------------------------------------------------------------------
// The block takes one item at a time. An add searches the known keys one by
// one and then updates the key's window. A query takes the key search, two
// passes over the key's window of n samples through the single read port of
// the sample memory, the bit-serial divider for the mean and again for the
// variance, and the bit-serial square root. A finished result waits in the
// output register while the next item is accepted.
module keyed_window_statistics_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 operation_i,
  input  logic [kws_pkg::KEY_W-1:0]            sensor_key_i,
  input  logic signed [kws_pkg::SAMPLE_W-1:0]  sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 status_o,
  output logic [kws_pkg::COUNT_W-1:0]          sample_count_o,
  output logic signed [kws_pkg::SAMPLE_W-1:0]  min_value_o,
  output logic signed [kws_pkg::SAMPLE_W-1:0]  max_value_o,
  output logic signed [kws_pkg::SAMPLE_W-1:0]  mean_value_o,
  output logic [kws_pkg::SAMPLE_W-1:0]         std_dev_o
);
  import kws_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_SEARCH = 9'b000000010,
    S_UPDATE = 9'b000000100,
    S_PASS1  = 9'b000001000,
    S_MEAN   = 9'b000010000,
    S_PASS2  = 9'b000100000,
    S_VAR    = 9'b001000000,
    S_SQRT   = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [KEY_W-1:0]          key_table_q [SENSORS];
  logic [KCNT_W-1:0]         keys_q;
  logic [POS_W-1:0]          wpos_q [SENSORS];
  logic [CNT_W-1:0]          fill_q [SENSORS];
  logic signed [SAMPLE_W-1:0] mem [DEPTH];

  logic                      op_q;
  logic [KEY_W-1:0]          key_q;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic [KCNT_W-1:0]         idx_q;
  logic [SLOT_W-1:0]         slot_q;
  logic                      found_q, full_q;
  logic [ADDR_W-1:0]         base_q;
  logic [CNT_W-1:0]          n_q, i_q;
  logic                      rd_vld_q, a_vld_q, sq_vld_q, first_q;
  logic signed [SAMPLE_W-1:0] rd_data_q;
  logic signed [SUM_W-1:0]   sum_q;
  logic [SAMPLE_W-1:0]       a_q;
  logic [2*SAMPLE_W-1:0]     sq_q;
  logic [SQ_W-1:0]           acc_q;

  logic                      res_status_q;
  logic [CNT_W-1:0]          res_count_q;
  logic signed [SAMPLE_W-1:0] res_min_q, res_max_q, res_mean_q;
  logic [SAMPLE_W-1:0]       res_std_q;

  logic                      out_valid_q, out_status_q;
  logic [COUNT_W-1:0]        out_count_q;
  logic signed [SAMPLE_W-1:0] out_min_q, out_max_q, out_mean_q;
  logic [SAMPLE_W-1:0]       out_std_q;

  logic                      accept, hit, miss, rd_issue, pass1_end, pass2_end, load_out;
  logic [SLOT_W-1:0]         idx_slot;
  logic [ADDR_W-1:0]         rd_addr, wr_addr;
  logic                      mem_we;
  logic signed [SAMPLE_W:0]  diff;
  logic [SAMPLE_W:0]         diff_abs;
  logic [SUM_W-1:0]          sum_abs;
  unit_ctrl_t                div_ctrl, sqrt_ctrl;
  logic [DIV_W-1:0]          div_dividend, div_quot;
  logic [ROOT_W-1:0]         root;
  logic [DIV_W-1:0]          mean_q_full;
  logic [SAMPLE_W-1:0]       mean_mag;

  assign accept    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign idx_slot  = idx_q[SLOT_W-1:0];
  assign miss      = (idx_q == keys_q);
  assign hit       = !miss && (key_table_q[idx_slot] == key_q);
  assign rd_issue  = (state_q == S_PASS1 || state_q == S_PASS2) && (i_q != n_q);
  assign rd_addr   = base_q + ADDR_W'(i_q);
  assign wr_addr   = ADDR_W'(slot_q) * ADDR_W'(WINDOW) + ADDR_W'(wpos_q[slot_q]);
  assign mem_we    = (state_q == S_UPDATE) && !full_q;
  assign pass1_end = (state_q == S_PASS1) && (i_q == n_q) && !rd_vld_q;
  assign pass2_end = (state_q == S_PASS2) && (i_q == n_q) && !rd_vld_q && !a_vld_q
                     && !sq_vld_q;
  assign load_out  = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  assign diff      = {rd_data_q[SAMPLE_W-1], rd_data_q} - {res_mean_q[SAMPLE_W-1], res_mean_q};
  assign diff_abs  = diff[SAMPLE_W] ? (SAMPLE_W + 1)'(-diff) : (SAMPLE_W + 1)'(diff);
  assign sum_abs   = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);

  assign div_ctrl.start  = pass1_end || pass2_end;
  assign div_dividend    = (state_q == S_PASS1) ? DIV_W'(sum_abs) : acc_q;
  assign sqrt_ctrl.start = (state_q == S_VAR) && div_ctrl.done;
  assign mean_q_full     = div_quot;
  assign mean_mag        = mean_q_full[SAMPLE_W-1:0];

  kws_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_ctrl.start),
    .dividend_i (div_dividend),
    .divisor_i  (n_q),
    .done_o     (div_ctrl.done),
    .quotient_o (div_quot)
  );

  kws_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_ctrl.start),
    .radicand_i (div_quot[VAR_W-1:0]),
    .done_o     (sqrt_ctrl.done),
    .root_o     (root)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (accept) state_d = S_SEARCH;
      S_SEARCH: begin
        if (hit || miss) begin
          if (op_q == OP_ADD) begin
            state_d = S_UPDATE;
          end else if (miss || fill_q[idx_slot] == '0) begin
            state_d = S_DONE;
          end else begin
            state_d = S_PASS1;
          end
        end
      end
      S_UPDATE: state_d = S_DONE;
      S_PASS1:  if (pass1_end) state_d = S_MEAN;
      S_MEAN:   if (div_ctrl.done) state_d = S_PASS2;
      S_PASS2:  if (pass2_end) state_d = S_VAR;
      S_VAR:    if (div_ctrl.done) state_d = S_SQRT;
      S_SQRT:   if (sqrt_ctrl.done) state_d = S_DONE;
      S_DONE:   if (load_out) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      keys_q      <= '0;
      rd_vld_q    <= 1'b0;
      a_vld_q     <= 1'b0;
      sq_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      for (int s = 0; s < SENSORS; s++) begin
        wpos_q[s] <= '0;
        fill_q[s] <= '0;
      end
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_issue;
      a_vld_q  <= (state_q == S_PASS2) && rd_vld_q;
      sq_vld_q <= a_vld_q;
      if (mem_we) begin
        if (!found_q) begin
          keys_q <= keys_q + 1'b1;
        end
        wpos_q[slot_q] <= (wpos_q[slot_q] == POS_W'(WINDOW - 1)) ? '0
                          : wpos_q[slot_q] + 1'b1;
        if (fill_q[slot_q] != CNT_W'(WINDOW)) begin
          fill_q[slot_q] <= fill_q[slot_q] + 1'b1;
        end
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= sample_q;
    end
    rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we && !found_q) begin
      key_table_q[slot_q] <= key_q;
    end
    unique case (state_q)
      S_IDLE: begin
        op_q         <= operation_i;
        key_q        <= sensor_key_i;
        sample_q     <= sample_i;
        idx_q        <= '0;
        res_status_q <= ST_OK;
        res_count_q  <= '0;
        res_min_q    <= '0;
        res_max_q    <= '0;
        res_mean_q   <= '0;
        res_std_q    <= '0;
      end
      S_SEARCH: begin
        if (hit || miss) begin
          slot_q  <= idx_slot;
          found_q <= hit;
          full_q  <= miss && (idx_q == KCNT_W'(SENSORS));
          base_q  <= ADDR_W'(idx_q) * ADDR_W'(WINDOW);
          n_q     <= fill_q[idx_slot];
          i_q     <= '0;
          first_q <= 1'b1;
          sum_q   <= '0;
          if (op_q == OP_QUERY && (miss || fill_q[idx_slot] == '0)) begin
            res_status_q <= ST_MISS;
          end
        end else begin
          idx_q <= idx_q + 1'b1;
        end
      end
      S_PASS1: begin
        if (rd_issue) begin
          i_q <= i_q + 1'b1;
        end
        if (rd_vld_q) begin
          first_q <= 1'b0;
          sum_q   <= sum_q + SUM_W'(rd_data_q);
          if (first_q || rd_data_q < res_min_q) res_min_q <= rd_data_q;
          if (first_q || rd_data_q > res_max_q) res_max_q <= rd_data_q;
        end
        if (pass1_end) begin
          i_q         <= '0;
          acc_q       <= '0;
          res_count_q <= n_q;
        end
      end
      S_MEAN: begin
        if (div_ctrl.done) begin
          res_mean_q <= sum_q[SUM_W-1] ? -$signed(mean_mag) : $signed(mean_mag);
        end
      end
      S_PASS2: begin
        if (rd_issue) begin
          i_q <= i_q + 1'b1;
        end
        a_q  <= diff_abs[SAMPLE_W-1:0];
        sq_q <= a_q * a_q;
        if (sq_vld_q) begin
          acc_q <= acc_q + SQ_W'(sq_q);
        end
      end
      S_SQRT: begin
        if (sqrt_ctrl.done) begin
          res_std_q <= SAMPLE_W'(root);
        end
      end
      S_UPDATE, S_VAR, S_DONE: begin
      end
      default: begin
      end
    endcase
    if (load_out) begin
      out_status_q <= res_status_q;
      out_count_q  <= COUNT_W'(res_count_q);
      out_min_q    <= res_min_q;
      out_max_q    <= res_max_q;
      out_mean_q   <= res_mean_q;
      out_std_q    <= res_std_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign sample_count_o = out_count_q;
  assign min_value_o    = out_min_q;
  assign max_value_o    = out_max_q;
  assign mean_value_o   = out_mean_q;
  assign std_dev_o      = out_std_q;

endmodule

>>> hw/rtl/kws_div.sv
// ----------------------------------------------------------------------------
// kws_div
// Restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kws_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [kws_pkg::DIV_W-1:0] dividend_i,
  input  logic [kws_pkg::CNT_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [kws_pkg::DIV_W-1:0] quotient_o
);
  import kws_pkg::*;

  localparam int ITER_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0]  shift_q;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]  dvs_q;
  logic [ITER_W-1:0] iter_q;
  logic              busy_q, done_q;
  logic [CNT_W:0]    trial;
  logic              ge;

  assign trial = {rem_q, shift_q[DIV_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign rem_d = ge ? CNT_W'(trial - {1'b0, dvs_q}) : CNT_W'(trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        iter_q <= '0;
      end else if (busy_q) begin
        iter_q <= iter_q + 1'b1;
        if (iter_q == ITER_W'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      shift_q <= dividend_i;
      rem_q   <= '0;
      dvs_q   <= divisor_i;
    end else if (busy_q) begin
      shift_q <= {shift_q[DIV_W-2:0], ge};
      rem_q   <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = shift_q;

endmodule

>>> hw/rtl/kws_sqrt.sv
// ----------------------------------------------------------------------------
// kws_sqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module kws_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [kws_pkg::VAR_W-1:0]  radicand_i,
  output logic                       done_o,
  output logic [kws_pkg::ROOT_W-1:0] root_o
);
  import kws_pkg::*;

  localparam int ITER_W = $clog2(ROOT_W + 1);
  localparam int REM_W  = ROOT_W + 2;

  logic [VAR_W-1:0]  x_q;
  logic [REM_W-1:0]  rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [ITER_W-1:0] iter_q;
  logic              busy_q, done_q;
  logic [REM_W+1:0]  rem_t, trial;
  logic              ge;

  assign rem_t = {rem_q, x_q[VAR_W-1 -: 2]};
  assign trial = (REM_W + 2)'({root_q, 2'b01});
  assign ge    = rem_t >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        iter_q <= '0;
      end else if (busy_q) begin
        iter_q <= iter_q + 1'b1;
        if (iter_q == ITER_W'(ROOT_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      x_q    <= {x_q[VAR_W-3:0], 2'b00};
      rem_q  <= ge ? REM_W'(rem_t - trial) : REM_W'(rem_t);
      root_q <= {root_q[ROOT_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

>>> hw/rtl/kws_checker.sv
// ----------------------------------------------------------------------------
// kws_checker
// Port-level checks for the keyed window statistics block.
// ----------------------------------------------------------------------------
module kws_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_stall_o,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input logic                                 status_o,
  input logic [kws_pkg::COUNT_W-1:0]          sample_count_o,
  input logic signed [kws_pkg::SAMPLE_W-1:0]  min_value_o,
  input logic signed [kws_pkg::SAMPLE_W-1:0]  max_value_o,
  input logic signed [kws_pkg::SAMPLE_W-1:0]  mean_value_o,
  input logic [kws_pkg::SAMPLE_W-1:0]         std_dev_o
);
  import kws_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("Stalled result item was dropped.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("Block took a second item while the first was in work.");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> sample_count_o == '0 && min_value_o == '0 &&
    max_value_o == '0 && mean_value_o == '0 && std_dev_o == '0)
    else $error("Miss result carries nonzero fields.");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> sample_count_o <= COUNT_W'(WINDOW))
    else $error("Sample count exceeds the window.");

  a_mean_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !status_o && sample_count_o != '0 |->
    min_value_o <= mean_value_o && mean_value_o <= max_value_o)
    else $error("Mean lies outside the min and max.");

endmodule

bind keyed_window_statistics_core kws_checker u_kws_checker (.*);

>>> tb/keyed_window_statistics_core_tb.sv
// ----------------------------------------------------------------------------
// keyed_window_statistics_core_tb
// Drives add and query items into the keyed window statistics core and
// checks every result against a behavioral predictor of the key table and
// sample windows, with random idling and stalling on both channels.
// ----------------------------------------------------------------------------
module keyed_window_statistics_core_tb;
  import kws_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic                       status;
    logic [COUNT_W-1:0]         count;
    logic signed [SAMPLE_W-1:0] min_v;
    logic signed [SAMPLE_W-1:0] max_v;
    logic signed [SAMPLE_W-1:0] mean_v;
    logic [SAMPLE_W-1:0]        sd;
  } stats_t;

  typedef struct {
    op_e                        op;
    logic [KEY_W-1:0]           key;
    logic signed [SAMPLE_W-1:0] smp;
    logic                       fixed;
    stats_t                     want;
  } row_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic                       operation_i = 1'b0;
  logic [KEY_W-1:0]           sensor_key_i = '0;
  logic signed [SAMPLE_W-1:0] sample_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic                       status_o;
  logic [COUNT_W-1:0]         sample_count_o;
  logic signed [SAMPLE_W-1:0] min_value_o;
  logic signed [SAMPLE_W-1:0] max_value_o;
  logic signed [SAMPLE_W-1:0] mean_value_o;
  logic [SAMPLE_W-1:0]        std_dev_o;

  keyed_window_statistics_core dut (.*);

  always #5 clk_i = ~clk_i;

  logic [KEY_W-1:0]           known_keys [SENSORS];
  int unsigned                key_total;
  logic signed [SAMPLE_W-1:0] windows [SENSORS][WINDOW];
  int unsigned                head [SENSORS];
  int unsigned                held [SENSORS];

  stats_t      pending_stats [$];
  int unsigned fail_cnt;
  int unsigned result_cnt;
  int unsigned query_hits;
  int unsigned drop_cnt;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          hold_recv;

  function automatic int lookup_slot(logic [KEY_W-1:0] key);
    for (int i = 0; i < key_total; i++) begin
      if (known_keys[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic logic [63:0] floor_root(logic [63:0] x);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= x) root = trial;
    end
    return root;
  endfunction

  function automatic stats_t window_stats(op_e op, logic [KEY_W-1:0] key,
                                          logic signed [SAMPLE_W-1:0] smp);
    stats_t       r;
    int           slot;
    int unsigned  n;
    longint       total;
    longint       diff;
    logic [127:0] sq_sum;
    logic [127:0] quo;
    r = '{default: '0};
    slot = lookup_slot(key);
    if (op == OP_ADD) begin
      if (slot < 0 && key_total < SENSORS) begin
        slot = key_total;
        known_keys[slot] = key;
        key_total++;
      end
      if (slot < 0) begin
        drop_cnt++;
      end else begin
        windows[slot][head[slot]] = smp;
        head[slot] = (head[slot] + 1) % WINDOW;
        if (held[slot] < WINDOW) held[slot]++;
      end
      return r;
    end
    if (slot < 0 || held[slot] == 0) begin
      r.status = ST_MISS;
      return r;
    end
    query_hits++;
    n = held[slot];
    total = 0;
    r.min_v = windows[slot][0];
    r.max_v = windows[slot][0];
    for (int i = 0; i < n; i++) begin
      total += windows[slot][i];
      if (windows[slot][i] < r.min_v) r.min_v = windows[slot][i];
      if (windows[slot][i] > r.max_v) r.max_v = windows[slot][i];
    end
    r.mean_v = SAMPLE_W'(total / longint'(n));
    sq_sum = '0;
    for (int i = 0; i < n; i++) begin
      diff = longint'(windows[slot][i]) - longint'(r.mean_v);
      if (diff < 0) diff = -diff;
      sq_sum += 128'(diff) * 128'(diff);
    end
    quo = sq_sum / 128'(n);
    r.status = ST_OK;
    r.count = COUNT_W'(n);
    r.sd = SAMPLE_W'(floor_root(quo[63:0]));
    return r;
  endfunction

  task automatic send_item(op_e op, logic [KEY_W-1:0] key,
                           logic signed [SAMPLE_W-1:0] smp, bit fixed, stats_t want);
    stats_t got;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    sensor_key_i <= key;
    sample_i <= smp;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    got = window_stats(op, key, smp);
    if (fixed && (got.status !== want.status || got.count !== want.count ||
                  got.min_v !== want.min_v || got.max_v !== want.max_v ||
                  got.mean_v !== want.mean_v || got.sd !== want.sd)) begin
      $error("directed row: predictor disagrees with typed-in result for key %h", key);
      fail_cnt++;
    end
    pending_stats.push_back(got);
  endtask

  task automatic wait_drained();
    int unsigned guard;
    in_valid_i <= 1'b0;
    guard = 0;
    while (pending_stats.size() != 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (300) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (hold_recv) out_stall_i <= 1'b1;
    else out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    stats_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      result_cnt++;
      if (pending_stats.size() == 0) begin
        $error("result with no item outstanding");
        fail_cnt++;
      end else begin
        e = pending_stats.pop_front();
        if (status_o !== e.status) begin
          $error("status expected %0d actual %0d", e.status, status_o); fail_cnt++;
        end
        if (sample_count_o !== e.count) begin
          $error("sample_count expected %0d actual %0d", e.count, sample_count_o);
          fail_cnt++;
        end
        if (min_value_o !== e.min_v) begin
          $error("min_value expected %0d actual %0d", e.min_v, min_value_o); fail_cnt++;
        end
        if (max_value_o !== e.max_v) begin
          $error("max_value expected %0d actual %0d", e.max_v, max_value_o); fail_cnt++;
        end
        if (mean_value_o !== e.mean_v) begin
          $error("mean_value expected %0d actual %0d", e.mean_v, mean_value_o);
          fail_cnt++;
        end
        if (std_dev_o !== e.sd) begin
          $error("std_dev expected %0d actual %0d", e.sd, std_dev_o); fail_cnt++;
        end
      end
    end
  end

  initial begin
    #50ms;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    row_t        rows [$];
    stats_t      z;
    stats_t      miss;
    stats_t      one_max;
    logic [KEY_W-1:0] pool [12];
    int unsigned k;
    op_e         op;
    z = '{default: '0};
    miss = z;
    miss.status = ST_MISS;
    one_max = '{ST_OK, 6'd1, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'd0};
    fail_cnt = 0;
    result_cnt = 0;
    query_hits = 0;
    drop_cnt = 0;
    key_total = 0;
    hold_recv = 1'b0;
    send_idle_pct = 13;
    recv_stall_pct = 84;
    foreach (head[i]) begin
      head[i] = 0;
      held[i] = 0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    rows.push_back('{OP_QUERY, 64'h0, 32'sh0, 1'b1, miss});
    rows.push_back('{OP_QUERY, '1, 32'sh0, 1'b1, miss});
    rows.push_back('{OP_ADD, '1, 32'sh7fffffff, 1'b1, z});
    rows.push_back('{OP_QUERY, '1, 32'sh0, 1'b1, one_max});
    rows.push_back('{OP_ADD, '1, 32'sh80000000, 1'b1, z});
    rows.push_back('{OP_QUERY, '1, 32'sh0, 1'b0, z});
    rows.push_back('{OP_ADD, 64'h0, 32'sh80000000, 1'b1, z});
    rows.push_back('{OP_ADD, 64'h0, 32'sh80000000, 1'b1, z});
    rows.push_back('{OP_QUERY, 64'h0, 32'sh0, 1'b0, z});
    rows.push_back('{OP_ADD, 64'h0, -32'sd3, 1'b1, z});
    rows.push_back('{OP_QUERY, 64'h0, 32'sh0, 1'b0, z});
    for (int i = 2; i < SENSORS; i++)
      rows.push_back('{OP_ADD, 64'hA5A5_0000_0000_0000 + i, 32'sh0001_8000 * i, 1'b1, z});
    rows.push_back('{OP_ADD, 64'h5A5A_5A5A_5A5A_5A5A, 32'sh1234, 1'b1, z});
    rows.push_back('{OP_QUERY, 64'h5A5A_5A5A_5A5A_5A5A, 32'sh0, 1'b1, miss});
    rows.push_back('{OP_QUERY, 64'hA5A5_0000_0000_0009, 32'sh0, 1'b0, z});
    foreach (rows[i]) send_item(rows[i].op, rows[i].key, rows[i].smp, rows[i].fixed,
                                rows[i].want);
    wait_drained();

    for (int i = 0; i < 70; i++)
      send_item(OP_ADD, '1, $urandom(), 1'b0, z);
    send_item(OP_QUERY, '1, 32'sh0, 1'b0, z);
    wait_drained();

    hold_recv = 1'b1;
    fork
      begin
        repeat (3000) @(posedge clk_i);
        hold_recv = 1'b0;
      end
      for (int i = 0; i < 6; i++)
        send_item(op_e'(i[0]), 64'h0, $urandom(), 1'b0, z);
    join
    wait_drained();

    for (int p = 0; p < 3; p++) begin
      if (p == 1) begin
        send_idle_pct = 84;
        recv_stall_pct = 13;
      end else if (p == 2) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      for (int i = 0; i < 12; i++)
        pool[i] = (i < key_total) ? known_keys[i] : {$urandom(), $urandom()};
      for (int i = 0; i < 660; i++) begin
        k = $urandom_range(11);
        op = ($urandom_range(99) < 65) ? OP_ADD : OP_QUERY;
        if ($urandom_range(19) == 0)
          send_item(op, {$urandom(), $urandom()}, $urandom(), 1'b0, z);
        else if ($urandom_range(9) == 0)
          send_item(op, pool[k], $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000,
                    1'b0, z);
        else
          send_item(op, pool[k], $urandom(), 1'b0, z);
      end
      wait_drained();
    end

    $display("Covered %0d results, %0d statistics queries hitting samples, %0d dropped adds.",
             result_cnt, query_hits, drop_cnt);
    if (fail_cnt == 0 && pending_stats.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> keyed_window_statistics_core.f
hw/rtl/kws_pkg.sv
hw/rtl/kws_div.sv
hw/rtl/kws_sqrt.sv
hw/rtl/keyed_window_statistics_core.sv
hw/rtl/kws_checker.sv
tb/keyed_window_statistics_core_tb.sv
